### src/dht_pkg.sv
// Shared types and constants for the double hash table engine.
`timescale 1ns / 1ps
`default_nettype none
package dht_pkg;
	localparam int TableDepth = 1024;
	localparam int AddrW = $clog2(TableDepth);
	localparam int SizeW = 11;
	localparam int KeyW = 32;
	localparam int ValW = 32;
	localparam int HashW = 32;
	localparam int StatusW = 3;

	localparam logic [StatusW-1:0] ST_INSERTED  = 3'd0;
	localparam logic [StatusW-1:0] ST_FULL      = 3'd1;
	localparam logic [StatusW-1:0] ST_DUPLICATE = 3'd2;
	localparam logic [StatusW-1:0] ST_FOUND     = 3'd3;
	localparam logic [StatusW-1:0] ST_NOT_FOUND = 3'd4;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_READ,
		S_CHECK,
		S_DONE
	} state_t;
endpackage
`default_nettype wire

### src/dht_mod.sv
// Bit-serial remainder unit: computes hash mod size and hash mod (size-1).
`timescale 1ns / 1ps
`default_nettype none
module dht_mod (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [dht_pkg::HashW-1:0]     hash,
	input  wire logic [dht_pkg::SizeW-1:0]     size,
	output logic                               done,
	output logic      [dht_pkg::SizeW-1:0]     rem_s,
	output logic      [dht_pkg::SizeW-1:0]     rem_s1
);
	localparam int CntW = $clog2(dht_pkg::HashW + 1);
	logic [dht_pkg::HashW-1:0] hash_q;
	logic [CntW-1:0] cnt_q;
	logic busy_q;
	logic [dht_pkg::SizeW:0] t0, t1;
	logic [dht_pkg::SizeW-1:0] size1;

	assign size1 = size - dht_pkg::SizeW'(1);
	assign t0 = {rem_s, hash_q[dht_pkg::HashW-1]};
	assign t1 = {rem_s1, hash_q[dht_pkg::HashW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CntW'(1);
				if (cnt_q == CntW'(dht_pkg::HashW - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// one restoring step per cycle, both divisors in parallel
	always_ff @(posedge clk) begin
		if (start) begin
			hash_q <= hash;
			rem_s <= '0;
			rem_s1 <= '0;
		end else if (busy_q) begin
			hash_q <= hash_q << 1;
			rem_s <= (t0 >= {1'b0, size}) ? dht_pkg::SizeW'(t0 - {1'b0, size})
				: dht_pkg::SizeW'(t0);
			rem_s1 <= (t1 >= {1'b0, size1}) ? dht_pkg::SizeW'(t1 - {1'b0, size1})
				: dht_pkg::SizeW'(t1);
		end
	end
endmodule
`default_nettype wire

### src/dht_store.sv
// Slot memory: occupied bit, key and value per entry, registered read.
`timescale 1ns / 1ps
`default_nettype none
module dht_store (
	input  wire logic                          clk,
	input  wire logic [dht_pkg::AddrW-1:0]     rd_addr,
	output logic                               rd_occ,
	output logic      [dht_pkg::KeyW-1:0]      rd_key,
	output logic      [dht_pkg::ValW-1:0]      rd_val,
	input  wire logic                          wr_en,
	input  wire logic [dht_pkg::AddrW-1:0]     wr_addr,
	input  wire logic                          wr_occ,
	input  wire logic [dht_pkg::KeyW-1:0]      wr_key,
	input  wire logic [dht_pkg::ValW-1:0]      wr_val
);
	localparam int W = 1 + dht_pkg::KeyW + dht_pkg::ValW;
	logic [W-1:0] mem_q [dht_pkg::TableDepth];
	logic [W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= {wr_occ, wr_key, wr_val};
		rd_q <= mem_q[rd_addr];
	end

	assign {rd_occ, rd_key, rd_val} = rd_q;
endmodule
`default_nettype wire

### src/double_hash_table_engine.sv
// Top level of the double hash table engine.
`timescale 1ns / 1ps
`default_nettype none
// Open-addressed hash table with double hashing. After reset the block runs a
// clearing pass over every slot of the slot memory before it takes requests.
// Each request first computes the two remainders (one bit-serial unit, a
// bit per cycle), then spends a memory read and a compare on each probe, and
// then hands the result to the output register, waiting while the output is
// stalled. An insert refused as full skips the probes. The next request is
// taken only once the block is idle again. Write table_size only while idle;
// it is saturated to 2..1024.
module double_hash_table_engine (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [dht_pkg::SizeW-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          req_type,
	input  wire logic [dht_pkg::HashW-1:0]     hash_value,
	input  wire logic [dht_pkg::KeyW-1:0]      entry_key,
	input  wire logic [dht_pkg::ValW-1:0]      entry_value,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [dht_pkg::StatusW-1:0]   status,
	output logic      [dht_pkg::ValW-1:0]      found_value
);
	localparam int AW = dht_pkg::AddrW;
	localparam int SW = dht_pkg::SizeW;

	dht_pkg::state_t state_q, state_d;
	logic [SW-1:0] tsize_q, eff_s;
	logic [SW-1:0] count_q, limit, n_q, slot_q, stride_q;
	logic [AW-1:0] clr_q;
	logic type_q;
	logic [dht_pkg::KeyW-1:0] key_q;
	logic [dht_pkg::ValW-1:0] val_q;
	logic [dht_pkg::StatusW-1:0] res_st_q;
	logic [dht_pkg::ValW-1:0] res_val_q;
	logic mod_start, mod_done;
	logic [SW-1:0] rem_s, rem_s1;
	logic rd_occ;
	logic [dht_pkg::KeyW-1:0] rd_key;
	logic [dht_pkg::ValW-1:0] rd_val;
	logic wr_en, wr_occ;
	logic [AW-1:0] wr_addr, rd_addr;
	logic accept, hit, last, full_now;
	logic [SW:0] nxt_sum;
	logic [SW-1:0] nxt_slot;

	assign eff_s = (tsize_q < SW'(2)) ? SW'(2)
		: (tsize_q > SW'(dht_pkg::TableDepth)) ? SW'(dht_pkg::TableDepth) : tsize_q;
	assign limit = (count_q < eff_s) ? count_q : eff_s;
	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != dht_pkg::S_IDLE);
	assign accept = in_valid && !in_stall;
	assign mod_start = accept;
	assign hit = rd_occ && (rd_key == key_q);
	assign full_now = (count_q >= eff_s);
	assign last = ((n_q + SW'(1)) >= ((type_q == dht_pkg::REQ_LOOKUP) ? limit : eff_s));
	assign nxt_sum = {1'b0, slot_q} + {1'b0, stride_q};
	assign nxt_slot = (nxt_sum >= {1'b0, eff_s}) ? SW'(nxt_sum - {1'b0, eff_s})
		: SW'(nxt_sum);
	assign rd_addr = AW'(slot_q);

	dht_mod u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start), .hash(hash_value),
		.size(eff_s), .done(mod_done), .rem_s(rem_s), .rem_s1(rem_s1)
	);

	dht_store u_store (
		.clk(clk), .rd_addr(rd_addr), .rd_occ(rd_occ), .rd_key(rd_key),
		.rd_val(rd_val), .wr_en(wr_en), .wr_addr(wr_addr), .wr_occ(wr_occ),
		.wr_key(key_q), .wr_val(val_q)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dht_pkg::S_CLEAR: if (clr_q == AW'(dht_pkg::TableDepth - 1)) state_d = dht_pkg::S_IDLE;
			dht_pkg::S_IDLE: if (accept) state_d = dht_pkg::S_MOD;
			dht_pkg::S_MOD: begin
				if (mod_done) begin
					if (type_q == dht_pkg::REQ_INSERT && full_now) state_d = dht_pkg::S_DONE;
					else state_d = dht_pkg::S_READ;
				end
			end
			dht_pkg::S_READ: state_d = dht_pkg::S_CHECK;
			dht_pkg::S_CHECK: begin
				if (!rd_occ || hit || last) state_d = dht_pkg::S_DONE;
				else state_d = dht_pkg::S_READ;
			end
			dht_pkg::S_DONE: if (!out_valid || !out_stall) state_d = dht_pkg::S_IDLE;
			default: state_d = dht_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		wr_en = 1'b0;
		wr_occ = 1'b0;
		wr_addr = AW'(slot_q);
		unique case (state_q)
			dht_pkg::S_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = clr_q;
			end
			dht_pkg::S_CHECK: begin
				wr_en = (type_q == dht_pkg::REQ_INSERT) && !rd_occ;
				wr_occ = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dht_pkg::S_CLEAR;
			tsize_q <= SW'(1021);
			count_q <= '0;
			clr_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) tsize_q <= cfg_data;
			if (state_q == dht_pkg::S_CLEAR) clr_q <= clr_q + AW'(1);
			if (wr_en && state_q == dht_pkg::S_CHECK) count_q <= count_q + SW'(1);
			if (state_q == dht_pkg::S_DONE && (!out_valid || !out_stall)) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_q <= req_type;
			key_q <= entry_key;
			val_q <= entry_value;
		end
		unique case (state_q)
			dht_pkg::S_MOD: begin
				slot_q <= rem_s;
				stride_q <= rem_s1 + SW'(1);
				n_q <= '0;
				res_val_q <= '0;
				res_st_q <= (type_q == dht_pkg::REQ_INSERT) ? dht_pkg::ST_FULL
					: dht_pkg::ST_NOT_FOUND;
			end
			dht_pkg::S_CHECK: begin
				// advance the probe; status settles when the walk stops
				slot_q <= nxt_slot;
				n_q <= n_q + SW'(1);
				if (type_q == dht_pkg::REQ_INSERT) begin
					if (!rd_occ) res_st_q <= dht_pkg::ST_INSERTED;
					else if (hit) res_st_q <= dht_pkg::ST_DUPLICATE;
				end else if (hit) begin
					res_st_q <= dht_pkg::ST_FOUND;
					res_val_q <= rd_val;
				end
			end
			dht_pkg::S_DONE: begin
				if (!out_valid || !out_stall) begin
					status <= res_st_q;
					found_value <= res_val_q;
				end
			end
			default: ;
		endcase
	end

	// an insert that writes the memory must bump the count in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dht_pkg::S_CHECK && wr_en) |=> (count_q == $past(count_q) + SW'(1)))
		else $error("entry count missed an insert");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= SW'(dht_pkg::TableDepth))
		else $error("entry count exceeds table depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dht_pkg::S_READ) |-> (slot_q < eff_s))
		else $error("probe slot out of range");
endmodule
`default_nettype wire
